@@ sv/shc_pkg.sv @@
// shared types, constants and the crc-32c byte step for the segment header checker
// no dependencies; used by every module of the block by scoped names
package shc_pkg;

  localparam int unsigned SectionEntries = 6;
  localparam int unsigned HdrBytes       = 64;
  localparam int unsigned DirEntryBytes  = 32;
  localparam int unsigned DirEnd         = HdrBytes + DirEntryBytes * SectionEntries;
  localparam int unsigned AddrW          = $clog2(DirEnd);
  localparam int unsigned DirOffW        = $clog2(DirEntryBytes);
  localparam int unsigned MajorVersion   = 1;
  localparam int unsigned MinorVersion   = 0;

  localparam logic [31:0] CrcPoly = 32'h82f6_3b78;
  localparam logic [31:0] CrcInit = 32'hffff_ffff;

  localparam logic [63:0] MaxBytesReset = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MagicReset    = 64'h3130_4745_5345_5344;

  // configuration register indexes
  localparam logic [1:0] CfgMaxBytes = 2'd0;
  localparam logic [1:0] CfgMagic    = 2'd1;

  // last byte of each header field, and the first reserved byte
  localparam logic [5:0] PosMagic    = 6'd7;
  localparam logic [5:0] PosMajor    = 6'd9;
  localparam logic [5:0] PosMinor    = 6'd11;
  localparam logic [5:0] PosHdrSize  = 6'd15;
  localparam logic [5:0] PosSize     = 6'd23;
  localparam logic [5:0] PosId       = 6'd31;
  localparam logic [5:0] PosCount    = 6'd35;
  localparam logic [5:0] PosFlags    = 6'd39;
  localparam logic [5:0] PosCrc      = 6'd43;
  localparam logic [5:0] PosRsvFirst = 6'd44;

  // last byte of each directory entry field
  localparam logic [DirOffW-1:0] OffType   = DirOffW'(3);
  localparam logic [DirOffW-1:0] OffRsv    = DirOffW'(7);
  localparam logic [DirOffW-1:0] OffOffset = DirOffW'(15);
  localparam logic [DirOffW-1:0] OffLength = DirOffW'(23);

  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StTooLarge  = 4'd1,
    StShort     = 4'd2,
    StMagic     = 4'd3,
    StMajor     = 4'd4,
    StFeatures  = 4'd5,
    StHeader    = 4'd6,
    StReserved  = 4'd7,
    StCrc       = 4'd8,
    StDirectory = 4'd9,
    StTrailing  = 4'd10
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } shc_in_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] file_id;
    logic [31:0] body_crc;
  } shc_out_t;

  typedef struct packed {
    logic magic;
    logic major;
    logic feat;
    logic hdr;
    logic rsv;
    logic dir;
  } shc_err_t;

  typedef struct packed {
    logic [63:0] size;
    logic [63:0] id;
    logic [63:0] claimed_size;
    logic [63:0] next_offset;
    logic [31:0] stored_crc;
    shc_err_t    flags;
  } shc_view_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ sv/segment_header_checker.sv @@
// segment header checker top level: input register, parser, crc, status and result register
// depends on shc_pkg, shc_parser and shc_crc
// one byte item per cycle; each byte passes the input register, then the parser and crc
// logic, and a final byte's result is then captured in the result register
// only a result waiting on a stalled output can hold back a final byte
// async active-low reset clears all file state and loads the register defaults
module segment_header_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  shc_pkg::shc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output shc_pkg::shc_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i
);

  logic [63:0]        max_bytes_q;
  logic [63:0]        magic_q;
  logic               in_vld_q;
  shc_pkg::shc_in_t   in_q;
  logic               out_vld_q;
  shc_pkg::shc_out_t  out_q;
  shc_pkg::shc_out_t  out_d;
  logic               accept;
  logic               proc;
  logic               finish;
  logic               body;
  logic [31:0]        crc;
  shc_pkg::shc_view_t view;
  shc_pkg::status_e   status;

  assign proc        = in_vld_q && (!in_q.last_byte || !out_vld_q || !out_stall_i);
  assign finish      = proc && in_q.last_byte;
  assign in_stall_o  = in_vld_q && !proc;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  shc_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (proc),
    .clear_i (in_q.last_byte),
    .data_i  (in_q.data_byte),
    .magic_i (magic_q),
    .body_o  (body),
    .view_o  (view)
  );

  shc_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (proc),
    .body_i  (body),
    .clear_i (in_q.last_byte),
    .data_i  (in_q.data_byte),
    .crc_o   (crc)
  );

  always_comb begin
    if (view.size > max_bytes_q) status = shc_pkg::StTooLarge;
    else if (view.size < 64'(shc_pkg::DirEnd)) status = shc_pkg::StShort;
    else if (view.flags.magic) status = shc_pkg::StMagic;
    else if (view.flags.major) status = shc_pkg::StMajor;
    else if (view.flags.feat) status = shc_pkg::StFeatures;
    else if (view.flags.hdr || view.claimed_size != view.size) status = shc_pkg::StHeader;
    else if (view.flags.rsv) status = shc_pkg::StReserved;
    else if (~crc != view.stored_crc) status = shc_pkg::StCrc;
    else if (view.flags.dir) status = shc_pkg::StDirectory;
    else if (view.next_offset != view.size) status = shc_pkg::StTrailing;
    else status = shc_pkg::StOk;
    out_d = '{status: status, file_id: view.id, body_crc: ~crc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= shc_pkg::MaxBytesReset;
      magic_q     <= shc_pkg::MagicReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        shc_pkg::CfgMaxBytes: max_bytes_q <= cfg_data_i;
        shc_pkg::CfgMagic:    magic_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept || (in_vld_q && !proc);
      out_vld_q <= finish || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

endmodule

@@ sv/shc_crc.sv @@
// running crc-32c register, one byte per step over the file body
// depends on shc_pkg for the byte step and the initial value
module shc_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        body_i,
  input  logic        clear_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);

  logic [31:0] crc_q;
  logic [31:0] crc_d;

  assign crc_d = body_i ? shc_pkg::crc_byte(crc_q, data_i) : crc_q;
  assign crc_o = crc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= shc_pkg::CrcInit;
    end else if (step_i) begin
      crc_q <= clear_i ? shc_pkg::CrcInit : crc_d;
    end
  end

endmodule

@@ sv/shc_parser.sv @@
// header and directory field parser: byte counter, field shifter and latched error flags
// depends on shc_pkg for layout constants and the view struct
module shc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clear_i,
  input  logic [7:0]          data_i,
  input  logic [63:0]         magic_i,
  output logic                body_o,
  output shc_pkg::shc_view_t  view_o
);

  logic [63:0]       byte_count_q, byte_count_d;
  logic [63:0]       field_q, field_d;
  logic [63:0]       rec_size_q, rec_size_d;
  logic [63:0]       id_q, id_d;
  logic [31:0]       stored_crc_q, stored_crc_d;
  logic [63:0]       next_off_q, next_off_d;
  shc_pkg::shc_err_t flags_q, flags_d;

  logic                                        in_hdr;
  logic                                        in_dir;
  logic [shc_pkg::AddrW-1:0]                   rel;
  logic [shc_pkg::AddrW-shc_pkg::DirOffW-1:0]  entry;
  logic [shc_pkg::DirOffW-1:0]                 off;
  logic [64:0]                                 span;

  always_comb begin
    in_hdr       = byte_count_q < 64'(shc_pkg::HdrBytes);
    in_dir       = !in_hdr && (byte_count_q < 64'(shc_pkg::DirEnd));
    rel          = byte_count_q[shc_pkg::AddrW-1:0] - shc_pkg::AddrW'(shc_pkg::HdrBytes);
    entry        = rel[shc_pkg::AddrW-1:shc_pkg::DirOffW];
    off          = rel[shc_pkg::DirOffW-1:0];
    byte_count_d = (&byte_count_q) ? byte_count_q : byte_count_q + 64'd1;
    field_d      = {data_i, field_q[63:8]};
    span         = {1'b0, field_d} + {1'b0, next_off_q};
    rec_size_d   = rec_size_q;
    id_d         = id_q;
    stored_crc_d = stored_crc_q;
    next_off_d   = next_off_q;
    flags_d      = flags_q;

    if (in_hdr) begin
      unique case (byte_count_q[5:0])
        shc_pkg::PosMagic: begin
          if (field_d != magic_i) flags_d.magic = 1'b1;
        end
        shc_pkg::PosMajor: begin
          if (field_d[63:48] != 16'(shc_pkg::MajorVersion)) flags_d.major = 1'b1;
        end
        shc_pkg::PosMinor: begin
          if (field_d[63:48] > 16'(shc_pkg::MinorVersion)) flags_d.feat = 1'b1;
        end
        shc_pkg::PosHdrSize: begin
          if (field_d[63:32] != 32'(shc_pkg::HdrBytes)) flags_d.hdr = 1'b1;
        end
        shc_pkg::PosSize: begin
          rec_size_d = field_d;
        end
        shc_pkg::PosId: begin
          id_d = field_d;
          if (field_d == 64'd0) flags_d.hdr = 1'b1;
        end
        shc_pkg::PosCount: begin
          if (field_d[63:32] != 32'(shc_pkg::SectionEntries)) flags_d.hdr = 1'b1;
        end
        shc_pkg::PosFlags: begin
          if (field_d[63:32] != 32'd0) flags_d.feat = 1'b1;
        end
        shc_pkg::PosCrc: begin
          stored_crc_d = field_d[63:32];
        end
        default: begin
          if (byte_count_q[5:0] >= shc_pkg::PosRsvFirst && data_i != 8'd0) begin
            flags_d.rsv = 1'b1;
          end
        end
      endcase
    end else if (in_dir) begin
      unique case (off)
        shc_pkg::OffType: begin
          if (field_d[63:32] != 32'(entry) + 32'd1) flags_d.dir = 1'b1;
        end
        shc_pkg::OffRsv: begin
          if (field_d[63:32] != 32'd0) flags_d.dir = 1'b1;
        end
        shc_pkg::OffOffset: begin
          if (field_d != next_off_q) flags_d.dir = 1'b1;
        end
        shc_pkg::OffLength: begin
          // length must end within the recorded size
          if (span > {1'b0, rec_size_q}) flags_d.dir = 1'b1;
          else next_off_d = span[63:0];
        end
        default: ;
      endcase
    end
  end

  assign body_o = !in_hdr;

  // flags, claimed size and next offset are final before the end of the directory
  assign view_o = '{
    size:          byte_count_d,
    id:            id_d,
    claimed_size:  rec_size_q,
    next_offset:   next_off_q,
    stored_crc:    stored_crc_q,
    flags:         flags_q
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      field_q      <= '0;
      rec_size_q   <= '0;
      id_q         <= '0;
      stored_crc_q <= '0;
      next_off_q   <= 64'(shc_pkg::DirEnd);
      flags_q      <= '0;
    end else if (step_i) begin
      if (clear_i) begin
        byte_count_q <= '0;
        field_q      <= '0;
        rec_size_q   <= '0;
        id_q         <= '0;
        stored_crc_q <= '0;
        next_off_q   <= 64'(shc_pkg::DirEnd);
        flags_q      <= '0;
      end else begin
        byte_count_q <= byte_count_d;
        field_q      <= field_d;
        rec_size_q   <= rec_size_d;
        id_q         <= id_d;
        stored_crc_q <= stored_crc_d;
        next_off_q   <= next_off_d;
        flags_q      <= flags_d;
      end
    end
  end

endmodule

@@ sv/shc_checker.sv @@
// port-level checks for the segment header checker, bound to the top level
// depends on shc_pkg for the port types and status codes
module shc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input shc_pkg::shc_out_t out_data_o
);

  // input is held back only by a result waiting on the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= shc_pkg::StTrailing))
    else $error("status code out of range");

  // a clean file must carry a nonzero segment id
  a_ok_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == shc_pkg::StOk) |-> (out_data_o.file_id != 64'd0))
    else $error("ok status with zero segment id");

endmodule

bind segment_header_checker shc_checker u_shc_checker (.*);

@@ tb/segment_header_checker_test.sv @@
// self-checking bench for segment_header_checker: streams segment files byte by byte
// and predicts status, segment id and body crc-32c for each final byte in a local model
// depends on shc_pkg and segment_header_checker
module segment_header_checker_test;
  import shc_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  typedef enum int {
    MutNone, MutMagic, MutMajor, MutMinor, MutHdrSize, MutRecSize, MutZeroId, MutCount,
    MutFlags, MutCrc, MutReserved, MutDirType, MutDirRsv, MutDirOffset, MutDirLength,
    MutTrailing, MutFlip
  } mutation_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  shc_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  shc_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgMaxBytes;
  logic [63:0] cfg_data_i = '0;

  // local copy of the registers and of the file state
  logic [63:0] cfg_max_bytes = MaxBytesReset;
  logic [63:0] cfg_magic = MagicReset;
  logic [63:0] file_len;
  logic [63:0] shreg;
  logic [63:0] rec_size;
  logic [63:0] seg_id;
  logic [63:0] dir_cursor;
  logic [31:0] crc_acc;
  logic [31:0] hdr_crc;
  logic        err_magic, err_major, err_feat, err_hdr, err_rsv, err_dir;

  shc_out_t    pending_results[$];
  logic [7:0]  file_buf[$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  bit          mismatch_seen = 1'b0;

  segment_header_checker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] crc32c_next(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ d[i]) ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_file_state();
    file_len   = '0;
    shreg      = '0;
    rec_size   = '0;
    seg_id     = '0;
    dir_cursor = 64'(DirEnd);
    crc_acc    = CrcInit;
    hdr_crc    = '0;
    {err_magic, err_major, err_feat, err_hdr, err_rsv, err_dir} = '0;
  endfunction

  function automatic void absorb_byte(input shc_in_t item);
    logic [63:0]        pos;
    logic [63:0]        rel;
    logic [63:0]        entry;
    logic [DirOffW-1:0] fld;
    shc_out_t           res;
    pos = file_len;
    if (file_len != '1) file_len++;
    shreg = {item.data_byte, shreg[63:8]};
    if (pos < 64'(HdrBytes)) begin
      case (pos[5:0])
        PosMagic:   if (shreg != cfg_magic) err_magic = 1'b1;
        PosMajor:   if (shreg[63:48] != 16'(MajorVersion)) err_major = 1'b1;
        PosMinor:   if (shreg[63:48] > 16'(MinorVersion)) err_feat = 1'b1;
        PosHdrSize: if (shreg[63:32] != 32'(HdrBytes)) err_hdr = 1'b1;
        PosSize:    rec_size = shreg;
        PosId: begin
          seg_id = shreg;
          if (shreg == '0) err_hdr = 1'b1;
        end
        PosCount:   if (shreg[63:32] != 32'(SectionEntries)) err_hdr = 1'b1;
        PosFlags:   if (shreg[63:32] != '0) err_feat = 1'b1;
        PosCrc:     hdr_crc = shreg[63:32];
        default:    if (pos[5:0] >= PosRsvFirst && item.data_byte != 8'd0) err_rsv = 1'b1;
      endcase
    end else begin
      crc_acc = crc32c_next(crc_acc, item.data_byte);
      if (pos < 64'(DirEnd)) begin
        rel   = pos - 64'(HdrBytes);
        entry = rel / 64'(DirEntryBytes);
        fld   = rel[DirOffW-1:0];
        case (fld)
          OffType:   if (shreg[63:32] != 32'(entry) + 32'd1) err_dir = 1'b1;
          OffRsv:    if (shreg[63:32] != '0) err_dir = 1'b1;
          OffOffset: if (shreg != dir_cursor) err_dir = 1'b1;
          OffLength: begin
            if (dir_cursor > rec_size || shreg > rec_size - dir_cursor) err_dir = 1'b1;
            else dir_cursor += shreg;
          end
          default: ;
        endcase
      end
    end
    if (item.last_byte) begin
      if (file_len > cfg_max_bytes) res.status = StTooLarge;
      else if (file_len < 64'(DirEnd)) res.status = StShort;
      else if (err_magic) res.status = StMagic;
      else if (err_major) res.status = StMajor;
      else if (err_feat) res.status = StFeatures;
      else if (err_hdr || rec_size != file_len) res.status = StHeader;
      else if (err_rsv) res.status = StReserved;
      else if (~crc_acc != hdr_crc) res.status = StCrc;
      else if (err_dir) res.status = StDirectory;
      else if (dir_cursor != file_len) res.status = StTrailing;
      else res.status = StOk;
      res.file_id  = seg_id;
      res.body_crc = ~crc_acc;
      pending_results = {pending_results, res};
      clear_file_state();
    end
  endfunction

  always @(posedge clk_i) begin : receiver
    shc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: status %0d", out_data_o.status);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          mismatch_seen = 1'b1;
        end
        if (out_data_o.file_id !== want.file_id) begin
          $error("file_id: expected %h, got %h", want.file_id, out_data_o.file_id);
          mismatch_seen = 1'b1;
        end
        if (out_data_o.body_crc !== want.body_crc) begin
          $error("body_crc: expected %h, got %h", want.body_crc, out_data_o.body_crc);
          mismatch_seen = 1'b1;
        end
      end
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] value, input logic fin);
    shc_in_t item;
    item.data_byte = value;
    item.last_byte = fin;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_byte(item);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] reg_index, input logic [63:0] value);
    wait_results();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (reg_index == CfgMaxBytes) cfg_max_bytes = value;
    else cfg_magic = value;
  endtask

  function automatic void put_le(input int pos, input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) file_buf[pos + i] = v[8*i +: 8];
  endfunction

  function automatic void flip_bit(input int lo, input int hi);
    file_buf[$urandom_range(hi, lo)] ^= 8'(1 << $urandom_range(7));
  endfunction

  // well-formed file apart from the crc field, with sections packed back to back after the directory
  function automatic void compose_file(input int body_len);
    int          remain;
    int          len;
    int          base;
    logic [63:0] off;
    logic [63:0] id;
    file_buf.delete();
    for (int i = 0; i < DirEnd + body_len; i++) begin
      file_buf = {file_buf, ((i >= DirEnd) ? 8'($urandom) : 8'h00)};
    end
    id = {$urandom, $urandom};
    if (id == '0) id = 64'd1;
    put_le(0, cfg_magic, 8);
    put_le(8, 64'(MajorVersion), 2);
    put_le(10, 64'(MinorVersion), 2);
    put_le(12, 64'(HdrBytes), 4);
    put_le(16, 64'(DirEnd + body_len), 8);
    put_le(24, id, 8);
    put_le(32, 64'(SectionEntries), 4);
    off    = 64'(DirEnd);
    remain = body_len;
    for (int e = 0; e < SectionEntries; e++) begin
      len  = (e == SectionEntries - 1) ? remain : $urandom_range(remain);
      base = HdrBytes + e * DirEntryBytes;
      put_le(base, 64'(e + 1), 4);
      put_le(base + 8, off, 8);
      put_le(base + 16, 64'(len), 8);
      put_le(base + 24, {$urandom, $urandom}, 8);
      off    += 64'(len);
      remain -= len;
    end
  endfunction

  function automatic void seal_crc();
    logic [31:0] c;
    c = CrcInit;
    for (int i = HdrBytes; i < file_buf.size(); i++) c = crc32c_next(c, file_buf[i]);
    put_le(40, {32'd0, ~c}, 4);
  endfunction

  task automatic emit_file(input int max_body);
    int        kind;
    int        body_len;
    int        base;
    int        cut;
    mutation_e mut;
    kind     = $urandom_range(99);
    body_len = ($urandom_range(15) == 0) ? $urandom_range(600) : $urandom_range(max_body);
    if (kind < 25) begin
      file_buf.delete();
      repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 400 : 40)) begin
        file_buf = {file_buf, 8'($urandom)};
      end
    end else begin
      compose_file(body_len);
      mut  = (kind < 55) ? MutNone : mutation_e'($urandom_range(MutFlip));
      base = HdrBytes + DirEntryBytes * $urandom_range(SectionEntries - 1);
      case (mut)
        MutMagic:     flip_bit(0, 7);
        MutMajor:     flip_bit(8, 9);
        MutMinor:     flip_bit(10, 11);
        MutHdrSize:   flip_bit(12, 15);
        MutRecSize:   flip_bit(16, 23);
        MutZeroId:    put_le(24, '0, 8);
        MutCount:     flip_bit(32, 35);
        MutFlags:     flip_bit(36, 39);
        MutReserved:  flip_bit(44, 63);
        MutDirType:   flip_bit(base, base + 3);
        MutDirRsv:    flip_bit(base + 4, base + 7);
        MutDirOffset: flip_bit(base + 8, base + 15);
        MutDirLength: flip_bit(base + 16, base + 23);
        MutTrailing: begin
          repeat ($urandom_range(1, 8)) file_buf = {file_buf, 8'($urandom)};
          put_le(16, 64'(file_buf.size()), 8);
        end
        MutFlip:      flip_bit(0, file_buf.size() - 1);
        default: ;
      endcase
      seal_crc();
      if (mut == MutCrc) flip_bit(40, 43);
      if (kind >= 80) begin
        cut = $urandom_range(1, DirEnd - 1);
        while (file_buf.size() > cut) void'(file_buf.pop_back());
      end
    end
    foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
  endtask

  task automatic run_files(input int n_files, input int max_body);
    repeat (n_files) begin
      emit_file(max_body);
      if ($urandom_range(7) == 0) wait_results();
    end
  endtask

  task automatic test_short_files();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(cfg_magic[8*i +: 8], i == 7);
    for (int i = 0; i < 8; i++) send_byte(~cfg_magic[8*i +: 8], i == 7);
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    run_files(1, 32);
  endtask

  // output held off while single-byte files keep coming, so the input backs up
  task automatic test_hold_off();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 300;
    repeat (30) send_byte(8'($urandom), 1'b1);
    wait_results();
  endtask

  task automatic test_register_settings();
    idle_pct  = 11;
    stall_pct = 11;
    write_reg(CfgMaxBytes, '0);
    run_files(1, 16);
    write_reg(CfgMaxBytes, 64'(DirEnd + 44));
    run_files(1, 90);
    write_reg(CfgMaxBytes, '1);
    write_reg(CfgMagic, {$urandom, $urandom});
    run_files(1, 16);
    write_reg(CfgMagic, MagicReset);
  endtask

  initial begin
    clear_file_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_short_files();
    test_random_traffic(0, 0);
    test_random_traffic(66, 0);
    test_random_traffic(0, 66);
    test_random_traffic(11, 11);
    test_hold_off();
    test_register_settings();
    wait_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_seen || pending_results.size() != 0) begin
      $display("TB_ERROR");
    end else begin
      $display("TB_OK");
    end
    $finish;
  end

endmodule
